[rtl/core/dkfh_pkg.sv]
// dkfh_pkg: shared types, constants and digit helpers for the decimal key folding hash
// used by decimal_key_folding_hash_core and dkfh_mod_reduce; no dependencies
`default_nettype none

package dkfh_pkg;

  // hash mode codes
  localparam logic [1:0] MODE_MODULO   = 2'd0;
  localparam logic [1:0] MODE_SHIFT    = 2'd1;
  localparam logic [1:0] MODE_BOUNDARY = 2'd2;

  // weights of the upper three digit groups, taken mod 2**32
  localparam logic [31:0] W_GROUP0 = 32'd3567587328;  // 10**12 mod 2**32
  localparam logic [31:0] W_GROUP1 = 32'd100000000;
  localparam logic [31:0] W_GROUP2 = 32'd10000;

  localparam int unsigned GROUP_W = 14;  // a 4-digit group is below 10000
  localparam int unsigned FOLD_W  = 16;  // a sum of four groups is below 40000
  localparam int unsigned INDEX_W = 10;

  typedef logic [GROUP_W-1:0] group_t;

  // sideband that travels with each item
  typedef struct packed {
    logic valid;
    logic bad;   // some nibble above nine
    logic kill;  // force the index to zero
  } dkfh_side_t;

  // decimal value of four packed bcd digits
  function automatic group_t bcd4(input logic [15:0] n);
    group_t v;
    v = group_t'(n[15:12]) * group_t'(1000) + group_t'(n[11:8]) * group_t'(100)
      + group_t'(n[7:4]) * group_t'(10) + group_t'(n[3:0]);
    return v;
  endfunction

  // digits reversed after dropping leading zeros
  function automatic group_t rev4(input logic [15:0] n);
    group_t v;
    if (n[15:12] != 4'd0) begin
      v = group_t'(n[3:0]) * group_t'(1000) + group_t'(n[7:4]) * group_t'(100)
        + group_t'(n[11:8]) * group_t'(10) + group_t'(n[15:12]);
    end else if (n[11:8] != 4'd0) begin
      v = group_t'(n[3:0]) * group_t'(100) + group_t'(n[7:4]) * group_t'(10)
        + group_t'(n[11:8]);
    end else if (n[7:4] != 4'd0) begin
      v = group_t'(n[3:0]) * group_t'(10) + group_t'(n[7:4]);
    end else begin
      v = group_t'(n[3:0]);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dkfh_mod_reduce.sv]
// dkfh_mod_reduce: three-stage reduction of a 32-bit code mod TABLE_SIZE
// by reciprocal multiply and one correction; depends on dkfh_pkg
`default_nettype none

module dkfh_mod_reduce #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  dkfh_pkg::dkfh_side_t                in_side,
  input  wire  [31:0]                         in_code,
  output dkfh_pkg::dkfh_side_t                out_side,
  output logic [dkfh_pkg::INDEX_W-1:0]        out_index
);
  import dkfh_pkg::*;

  localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(TABLE_SIZE);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam int unsigned QW      = 33 - $clog2(TABLE_SIZE);
  localparam int unsigned RW      = $clog2(TABLE_SIZE) + 1;

  dkfh_side_t       r1_side_r, r2_side_r, r3_side_r;
  logic [31:0]      r1_code_r;
  logic [63:0]      r1_prod_r, r1_prod_nxt;
  logic [QW-1:0]    quot;
  logic [31:0]      qn;
  logic [RW-1:0]    r2_rem_r, r2_rem_nxt;
  logic [RW-1:0]    rem_adj;
  logic [31:0]      rem_ext;
  logic [INDEX_W-1:0] r3_index_r, r3_index_nxt;

  // quotient estimate is low by at most one
  assign r1_prod_nxt = 64'(in_code) * 64'(RECIP);
  assign quot        = r1_prod_r[32+QW-1:32];
  assign qn          = 32'(quot) * 32'(TABLE_SIZE);
  assign r2_rem_nxt  = RW'(r1_code_r - qn);
  assign rem_adj     = (r2_rem_r >= RW'(TABLE_SIZE)) ? r2_rem_r - RW'(TABLE_SIZE) : r2_rem_r;
  assign rem_ext     = 32'(rem_adj);
  assign r3_index_nxt = r2_side_r.kill ? '0 : rem_ext[INDEX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_side_r <= '0;
      r2_side_r <= '0;
      r3_side_r <= '0;
    end else begin
      r1_side_r <= in_side;
      r2_side_r <= r1_side_r;
      r3_side_r <= r2_side_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_code_r  <= in_code;
    r1_prod_r  <= r1_prod_nxt;
    r2_rem_r   <= r2_rem_nxt;
    r3_index_r <= r3_index_nxt;
  end

  assign out_side  = r3_side_r;
  assign out_index = r3_index_r;

endmodule

`default_nettype wire

[rtl/core/decimal_key_folding_hash_core.sv]
// decimal_key_folding_hash_core: top level of the bcd key hash pipeline
// depends on dkfh_pkg and dkfh_mod_reduce
`default_nettype none

// Takes one 16-digit packed bcd key per clock and returns its table index
// on out_hash_index with out_strobe high for one cycle. busy is always low,
// so a new key can be started every cycle; the path is three stages of digit
// decode, group weighting and code selection followed by three stages of the
// reciprocal-multiply modulo unit. There is no backpressure on the result
// side. cfg_ready is always high; hash_mode may only be rewritten while no
// key is in flight. A key with a nibble above nine gives index zero with
// out_key_invalid set, and mode 3 gives index zero.
module decimal_key_folding_hash_core #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [63:0] in_key_digits,
  output logic        out_strobe,
  output logic [9:0]  out_hash_index,
  output logic        out_key_invalid,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_hash_mode
);
  import dkfh_pkg::*;

  logic [1:0]  mode_r;

  // stage 1: group values and reversed groups
  logic        s1_valid_r;
  group_t      s1_g_r [4];
  group_t      s1_rev1_r, s1_rev3_r;
  logic        s1_bad_r, s1_bad_nxt;
  logic [1:0]  s1_mode_r;

  // stage 2: weighted groups and fold sums
  logic        s2_valid_r;
  logic [31:0] s2_p0_r, s2_p1_r, s2_p2_r;
  group_t      s2_p3_r;
  logic [FOLD_W-1:0] s2_fold_r, s2_bound_r;
  logic        s2_bad_r;
  logic [1:0]  s2_mode_r;

  // stage 3: selected code
  dkfh_side_t  s3_side_r, s3_side_nxt;
  logic [31:0] s3_code_r, s3_code_nxt;

  dkfh_side_t  red_side;
  logic [INDEX_W-1:0] red_index;

  always_comb begin
    s1_bad_nxt = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (in_key_digits[4*i +: 4] > 4'd9) begin
        s1_bad_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    s3_side_nxt.valid = s2_valid_r;
    s3_side_nxt.bad   = s2_bad_r;
    s3_side_nxt.kill  = s2_bad_r;
    case (s2_mode_r)
      MODE_MODULO:   s3_code_nxt = s2_p0_r + s2_p1_r + s2_p2_r + 32'(s2_p3_r);
      MODE_SHIFT:    s3_code_nxt = 32'(s2_fold_r);
      MODE_BOUNDARY: s3_code_nxt = 32'(s2_bound_r);
      default: begin
        s3_code_nxt      = '0;
        s3_side_nxt.kill = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_MODULO;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_side_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_hash_mode;
      end
      s1_valid_r <= start && !busy;
      s2_valid_r <= s1_valid_r;
      s3_side_r  <= s3_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1_g_r[i] <= bcd4(in_key_digits[48-16*i +: 16]);
    end
    s1_rev1_r <= rev4(in_key_digits[32 +: 16]);
    s1_rev3_r <= rev4(in_key_digits[0 +: 16]);
    s1_bad_r  <= s1_bad_nxt;
    s1_mode_r <= mode_r;

    s2_p0_r    <= 32'(46'(s1_g_r[0]) * 46'(W_GROUP0));
    s2_p1_r    <= 32'(46'(s1_g_r[1]) * 46'(W_GROUP1));
    s2_p2_r    <= 32'(46'(s1_g_r[2]) * 46'(W_GROUP2));
    s2_p3_r    <= s1_g_r[3];
    s2_fold_r  <= FOLD_W'(s1_g_r[0]) + FOLD_W'(s1_g_r[1])
                + FOLD_W'(s1_g_r[2]) + FOLD_W'(s1_g_r[3]);
    s2_bound_r <= FOLD_W'(s1_g_r[0]) + FOLD_W'(s1_rev1_r)
                + FOLD_W'(s1_g_r[2]) + FOLD_W'(s1_rev3_r);
    s2_bad_r   <= s1_bad_r;
    s2_mode_r  <= s1_mode_r;

    s3_code_r  <= s3_code_nxt;
  end

  dkfh_mod_reduce #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_side   (s3_side_r),
    .in_code   (s3_code_r),
    .out_side  (red_side),
    .out_index (red_index)
  );

  assign busy            = 1'b0;
  assign cfg_ready       = 1'b1;
  assign out_strobe      = red_side.valid;
  assign out_hash_index  = red_index;
  assign out_key_invalid = red_side.bad;

endmodule

`default_nettype wire
